FILE: hw/rtl/hre_pkg.sv
// ----------------------------------------------------------------------------
// hre_pkg
// Shared types and constants of the homography reprojection error unit.
// ----------------------------------------------------------------------------
package hre_pkg;

  // Payload widths
  localparam int CoordW   = 16;               // Q12.4 input coordinate
  localparam int RefW     = 20;               // destination point in Q.8
  localparam int NumW     = 49;               // signed numerator, Q.28
  localparam int NumMagW  = NumW - 1;         // numerator magnitude
  localparam int DenW     = 57;               // signed denominator, Q.42
  localparam int DenMagW  = DenW - 1;         // denominator magnitude
  localparam int FracShift = 22;              // quotient is N * 2^22 / D
  localparam int DivSteps = 31;               // quotient bits below clamp
  localparam int FeedW    = DivSteps - FracShift;
  localparam int QMagW    = DivSteps;         // clamped quotient magnitude
  localparam int DeltaW   = 32;               // signed coordinate error
  localparam int AbsW     = 31;               // its magnitude
  localparam int SqW      = 64;               // squared distance, padded
  localparam int RootW    = 32;
  localparam int SqRemW   = RootW + 2;
  localparam int DistW    = 24;
  localparam int StatusW  = 2;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 40;

  // Projected coordinate clamp, 2^30 in Q.8
  localparam logic [QMagW-1:0] CoordClamp = QMagW'(1) << 30;
  localparam logic [DistW-1:0] DistMax    = '1;

  // Status codes
  localparam logic [StatusW-1:0] StatOk      = 2'd0;
  localparam logic [StatusW-1:0] StatZeroDen = 2'd1;
  localparam logic [StatusW-1:0] StatSat     = 2'd2;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegCoefXx  = 4'd0;
  localparam logic [CfgAddrW-1:0] RegCoefXy  = 4'd1;
  localparam logic [CfgAddrW-1:0] RegOffsetX = 4'd2;
  localparam logic [CfgAddrW-1:0] RegCoefYx  = 4'd3;
  localparam logic [CfgAddrW-1:0] RegCoefYy  = 4'd4;
  localparam logic [CfgAddrW-1:0] RegOffsetY = 4'd5;
  localparam logic [CfgAddrW-1:0] RegPerspX  = 4'd6;
  localparam logic [CfgAddrW-1:0] RegPerspY  = 4'd7;

  // Sideband that travels with a point pair through the divider
  typedef struct packed {
    logic                   zero;
    logic                   neg_u;
    logic                   neg_v;
    logic                   ovf_u;
    logic                   ovf_v;
    logic signed [RefW-1:0] ref_x;
    logic signed [RefW-1:0] ref_y;
  } div_side_t;

endpackage

FILE: hw/rtl/hre_div.sv
// ----------------------------------------------------------------------------
// hre_div
// Pipelined restoring divider for both projected coordinates, one quotient
// bit per stage, sharing one denominator.
// ----------------------------------------------------------------------------
module hre_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  input  logic signed [hre_pkg::NumW-1:0]      num_u_i,
  input  logic signed [hre_pkg::NumW-1:0]      num_v_i,
  input  logic signed [hre_pkg::DenW-1:0]      den_i,
  input  logic signed [hre_pkg::RefW-1:0]      ref_x_i,
  input  logic signed [hre_pkg::RefW-1:0]      ref_y_i,
  output logic                                 vld_o,
  output logic [hre_pkg::DivSteps-1:0]         q_u_o,
  output logic [hre_pkg::DivSteps-1:0]         q_v_o,
  output logic [hre_pkg::DenMagW-1:0]          rem_u_o,
  output logic [hre_pkg::DenMagW-1:0]          rem_v_o,
  output logic [hre_pkg::DenMagW-1:0]          den_o,
  output hre_pkg::div_side_t                   side_o
);

  localparam int N = hre_pkg::DivSteps;
  localparam int DW = hre_pkg::DenMagW;
  localparam int NW = hre_pkg::NumMagW;

  logic                         vld_q  [N+1];
  logic [DW-1:0]                rem_u_q[N+1];
  logic [DW-1:0]                rem_v_q[N+1];
  logic [N-1:0]                 quo_u_q[N+1];
  logic [N-1:0]                 quo_v_q[N+1];
  logic [N-1:0]                 feed_u_q[N+1];
  logic [N-1:0]                 feed_v_q[N+1];
  logic [DW-1:0]                den_q  [N+1];
  hre_pkg::div_side_t           side_q [N+1];

  // Magnitudes and the overflow test for the entry stage
  logic [hre_pkg::NumW-1:0] nu_abs, nv_abs;
  logic [hre_pkg::DenW-1:0] dn_abs;
  logic [NW-1:0]            nu_mag, nv_mag;
  logic [DW-1:0]            dn_mag, nu_hi, nv_hi;
  logic                     ovf_u, ovf_v;

  always_comb begin
    nu_abs = num_u_i[hre_pkg::NumW-1] ? (~num_u_i + 1'b1) : num_u_i;
    nv_abs = num_v_i[hre_pkg::NumW-1] ? (~num_v_i + 1'b1) : num_v_i;
    dn_abs = den_i[hre_pkg::DenW-1] ? (~den_i + 1'b1) : den_i;
    nu_mag = nu_abs[NW-1:0];
    nv_mag = nv_abs[NW-1:0];
    dn_mag = dn_abs[DW-1:0];
    nu_hi  = DW'(nu_mag[NW-1:hre_pkg::FeedW]);
    nv_hi  = DW'(nv_mag[NW-1:hre_pkg::FeedW]);
    ovf_u  = nu_hi >= dn_mag;
    ovf_v  = nv_hi >= dn_mag;
  end

  // Entry stage: load the partial remainder and the dividend bits to feed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_u_q[0]  <= ovf_u ? '0 : nu_hi;
    rem_v_q[0]  <= ovf_v ? '0 : nv_hi;
    quo_u_q[0]  <= '0;
    quo_v_q[0]  <= '0;
    feed_u_q[0] <= {nu_mag[hre_pkg::FeedW-1:0], hre_pkg::FracShift'(0)};
    feed_v_q[0] <= {nv_mag[hre_pkg::FeedW-1:0], hre_pkg::FracShift'(0)};
    den_q[0]    <= dn_mag;
    side_q[0]   <= '{zero:  (den_i == '0),
                     neg_u: num_u_i[hre_pkg::NumW-1] ^ den_i[hre_pkg::DenW-1],
                     neg_v: num_v_i[hre_pkg::NumW-1] ^ den_i[hre_pkg::DenW-1],
                     ovf_u: ovf_u,
                     ovf_v: ovf_v,
                     ref_x: ref_x_i,
                     ref_y: ref_y_i};
  end

  // One quotient bit per stage: shift in a dividend bit, subtract if it fits
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [DW:0] tu, tv, dd, su, sv;
    logic        ge_u, ge_v;

    always_comb begin
      dd   = {1'b0, den_q[k-1]};
      tu   = {rem_u_q[k-1], feed_u_q[k-1][N-1]};
      tv   = {rem_v_q[k-1], feed_v_q[k-1][N-1]};
      ge_u = tu >= dd;
      ge_v = tv >= dd;
      su   = ge_u ? (tu - dd) : tu;
      sv   = ge_v ? (tv - dd) : tv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_u_q[k]  <= su[DW-1:0];
      rem_v_q[k]  <= sv[DW-1:0];
      quo_u_q[k]  <= {quo_u_q[k-1][N-2:0], ge_u};
      quo_v_q[k]  <= {quo_v_q[k-1][N-2:0], ge_v};
      feed_u_q[k] <= {feed_u_q[k-1][N-2:0], 1'b0};
      feed_v_q[k] <= {feed_v_q[k-1][N-2:0], 1'b0};
      den_q[k]    <= den_q[k-1];
      side_q[k]   <= side_q[k-1];
    end
  end

  assign vld_o   = vld_q[N];
  assign q_u_o   = quo_u_q[N];
  assign q_v_o   = quo_v_q[N];
  assign rem_u_o = rem_u_q[N];
  assign rem_v_o = rem_v_q[N];
  assign den_o   = den_q[N];
  assign side_o  = side_q[N];

endmodule

FILE: hw/rtl/hre_sqrt.sv
// ----------------------------------------------------------------------------
// hre_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Returns the floor root and the remainder.
// ----------------------------------------------------------------------------
module hre_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic                           zero_i,
  input  logic [hre_pkg::SqW-1:0]        sq_i,
  output logic                           vld_o,
  output logic                           zero_o,
  output logic [hre_pkg::RootW-1:0]      root_o,
  output logic [hre_pkg::SqRemW-1:0]     rem_o
);

  localparam int N  = hre_pkg::RootW;
  localparam int RW = hre_pkg::SqRemW;
  localparam int SW = hre_pkg::SqW;

  logic          vld_q [N+1];
  logic          zero_q[N+1];
  logic [SW-1:0] sq_q  [N+1];
  logic [RW-1:0] rem_q [N+1];
  logic [N-1:0]  root_q[N+1];

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= zero_i;
    sq_q[0]   <= sq_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  // Bring down two bits, try root*4+1, keep one root bit
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [RW-1:0] rt, trial;
    logic          ge;

    always_comb begin
      rt    = {rem_q[k-1][RW-3:0], sq_q[k-1][SW-1:SW-2]};
      trial = {root_q[k-1], 2'b01};
      ge    = rt >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[k] <= zero_q[k-1];
      sq_q[k]   <= {sq_q[k-1][SW-3:0], 2'b00};
      rem_q[k]  <= ge ? (rt - trial) : rt;
      root_q[k] <= {root_q[k-1][N-2:0], ge};
    end
  end

  assign vld_o  = vld_q[N];
  assign zero_o = zero_q[N];
  assign root_o = root_q[N];
  assign rem_o  = rem_q[N];

endmodule

FILE: hw/rtl/homography_reprojection_error_unit.sv
// ----------------------------------------------------------------------------
// homography_reprojection_error_unit
// Maps a source point through a 3x3 projective matrix and returns the
// Euclidean distance to its matched destination point.
// ----------------------------------------------------------------------------
// Takes one point pair in every clock cycle (busy never rises) and returns its
// result, marked by a one-cycle result_valid_o strobe; results come out in
// order and cannot be held off. Most of the pipeline lies in the two
// one-bit-per-stage pipelines: a 31-stage divider for the projected
// coordinates and a 32-stage square root for the distance. Write the matrix
// registers only while no pair is in flight.
module homography_reprojection_error_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [hre_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [hre_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // Point pair in
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hre_pkg::CoordW-1:0]   src_x_i,
  input  logic signed [hre_pkg::CoordW-1:0]   src_y_i,
  input  logic signed [hre_pkg::CoordW-1:0]   ref_x_i,
  input  logic signed [hre_pkg::CoordW-1:0]   ref_y_i,
  // Result out
  output logic                                result_valid_o,
  output logic [hre_pkg::DistW-1:0]           distance_o,
  output logic [hre_pkg::StatusW-1:0]         status_o
);

  localparam int NumW = hre_pkg::NumW;
  localparam int DenW = hre_pkg::DenW;
  localparam int RefW = hre_pkg::RefW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] coef_xx_q, coef_xy_q, offset_x_q;
  logic signed [31:0] coef_yx_q, coef_yy_q, offset_y_q;
  logic signed [39:0] persp_x_q, persp_y_q;

  // Write the addressed register, ignore addresses beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= 32'sd16777216;
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= 32'sd16777216;
      offset_y_q <= '0;
      persp_x_q  <= '0;
      persp_y_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        hre_pkg::RegCoefXx:  coef_xx_q  <= cfg_wdata_i[31:0];
        hre_pkg::RegCoefXy:  coef_xy_q  <= cfg_wdata_i[31:0];
        hre_pkg::RegOffsetX: offset_x_q <= cfg_wdata_i[31:0];
        hre_pkg::RegCoefYx:  coef_yx_q  <= cfg_wdata_i[31:0];
        hre_pkg::RegCoefYy:  coef_yy_q  <= cfg_wdata_i[31:0];
        hre_pkg::RegOffsetY: offset_y_q <= cfg_wdata_i[31:0];
        hre_pkg::RegPerspX:  persp_x_q  <= cfg_wdata_i[39:0];
        hre_pkg::RegPerspY:  persp_y_q  <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: products of the matrix terms with the source point
  // --------------------------------------------------------------------------
  logic                   s1_vld_q;
  logic signed [47:0]     p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [55:0]     p_px_q, p_py_q;
  logic signed [RefW-1:0] s1_rx_q, s1_ry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xx_q  <= coef_xx_q * src_x_i;
    p_xy_q  <= coef_xy_q * src_y_i;
    p_yx_q  <= coef_yx_q * src_x_i;
    p_yy_q  <= coef_yy_q * src_y_i;
    p_px_q  <= persp_x_q * src_x_i;
    p_py_q  <= persp_y_q * src_y_i;
    s1_rx_q <= $signed({ref_x_i, 4'b0000});
    s1_ry_q <= $signed({ref_y_i, 4'b0000});
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerators in Q.28 and the denominator in Q.42
  // --------------------------------------------------------------------------
  logic                   s2_vld_q;
  logic signed [NumW-1:0] num_u_q, num_v_q;
  logic signed [DenW-1:0] den_q;
  logic signed [RefW-1:0] s2_rx_q, s2_ry_q;
  logic signed [NumW-1:0] off_x_ext, off_y_ext;

  assign off_x_ext = $signed({{(NumW - 44){offset_x_q[31]}}, offset_x_q, 12'h000});
  assign off_y_ext = $signed({{(NumW - 44){offset_y_q[31]}}, offset_y_q, 12'h000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_u_q <= NumW'(p_xx_q) + NumW'(p_xy_q) + off_x_ext;
    num_v_q <= NumW'(p_yx_q) + NumW'(p_yy_q) + off_y_ext;
    den_q   <= DenW'(p_px_q) + DenW'(p_py_q) + (DenW'(1) << 42);
    s2_rx_q <= s1_rx_q;
    s2_ry_q <= s1_ry_q;
  end

  // --------------------------------------------------------------------------
  // Divider pipeline
  // --------------------------------------------------------------------------
  logic                             dv_vld;
  logic [hre_pkg::DivSteps-1:0]     dv_q_u, dv_q_v;
  logic [hre_pkg::DenMagW-1:0]      dv_rem_u, dv_rem_v, dv_den;
  hre_pkg::div_side_t               dv_side;

  hre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (s2_vld_q),
    .num_u_i (num_u_q),
    .num_v_i (num_v_q),
    .den_i   (den_q),
    .ref_x_i (s2_rx_q),
    .ref_y_i (s2_ry_q),
    .vld_o   (dv_vld),
    .q_u_o   (dv_q_u),
    .q_v_o   (dv_q_v),
    .rem_u_o (dv_rem_u),
    .rem_v_o (dv_rem_v),
    .den_o   (dv_den),
    .side_o  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Post stage 1: round to nearest and clamp the quotient magnitude
  // --------------------------------------------------------------------------
  logic                          r_vld_q, r_zero_q, r_neg_u_q, r_neg_v_q;
  logic [hre_pkg::QMagW-1:0]     r_mag_u_q, r_mag_v_q;
  logic signed [RefW-1:0]        r_rx_q, r_ry_q;
  logic                          up_u, up_v;
  logic [hre_pkg::QMagW:0]       qr_u, qr_v;
  logic [hre_pkg::QMagW-1:0]     mag_u, mag_v;

  always_comb begin
    up_u  = {dv_rem_u, 1'b0} >= {1'b0, dv_den};
    up_v  = {dv_rem_v, 1'b0} >= {1'b0, dv_den};
    qr_u  = {1'b0, dv_q_u} + (hre_pkg::QMagW + 1)'(up_u);
    qr_v  = {1'b0, dv_q_v} + (hre_pkg::QMagW + 1)'(up_v);
    mag_u = (dv_side.ovf_u || qr_u > {1'b0, hre_pkg::CoordClamp}) ?
            hre_pkg::CoordClamp : qr_u[hre_pkg::QMagW-1:0];
    mag_v = (dv_side.ovf_v || qr_v > {1'b0, hre_pkg::CoordClamp}) ?
            hre_pkg::CoordClamp : qr_v[hre_pkg::QMagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    r_zero_q  <= dv_side.zero;
    r_neg_u_q <= dv_side.neg_u;
    r_neg_v_q <= dv_side.neg_v;
    r_mag_u_q <= mag_u;
    r_mag_v_q <= mag_v;
    r_rx_q    <= dv_side.ref_x;
    r_ry_q    <= dv_side.ref_y;
  end

  // --------------------------------------------------------------------------
  // Post stage 2: apply the sign and take the coordinate error
  // --------------------------------------------------------------------------
  logic                              d_vld_q, d_zero_q;
  logic signed [hre_pkg::DeltaW-1:0] dx_q, dy_q;
  logic signed [hre_pkg::DeltaW-1:0] u_s, v_s;

  always_comb begin
    u_s = r_neg_u_q ? -$signed({1'b0, r_mag_u_q}) : $signed({1'b0, r_mag_u_q});
    v_s = r_neg_v_q ? -$signed({1'b0, r_mag_v_q}) : $signed({1'b0, r_mag_v_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_zero_q <= r_zero_q;
    dx_q     <= u_s - hre_pkg::DeltaW'(r_rx_q);
    dy_q     <= v_s - hre_pkg::DeltaW'(r_ry_q);
  end

  // --------------------------------------------------------------------------
  // Post stage 3: magnitudes of the error
  // --------------------------------------------------------------------------
  logic                        a_vld_q, a_zero_q;
  logic [hre_pkg::AbsW-1:0]    adx_q, ady_q;
  logic [hre_pkg::DeltaW-1:0]  adx_full, ady_full;

  always_comb begin
    adx_full = dx_q[hre_pkg::DeltaW-1] ? -dx_q : dx_q;
    ady_full = dy_q[hre_pkg::DeltaW-1] ? -dy_q : dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_zero_q <= d_zero_q;
    adx_q    <= adx_full[hre_pkg::AbsW-1:0];
    ady_q    <= ady_full[hre_pkg::AbsW-1:0];
  end

  // --------------------------------------------------------------------------
  // Post stages 4 and 5: square, then sum
  // --------------------------------------------------------------------------
  logic                            m_vld_q, m_zero_q, s_vld_q, s_zero_q;
  logic [2*hre_pkg::AbsW-1:0]      sqx_q, sqy_q;
  logic [hre_pkg::SqW-1:0]         sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      m_vld_q <= a_vld_q;
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_zero_q <= a_zero_q;
    sqx_q    <= adx_q * adx_q;
    sqy_q    <= ady_q * ady_q;
    s_zero_q <= m_zero_q;
    sum_q    <= hre_pkg::SqW'(sqx_q) + hre_pkg::SqW'(sqy_q);
  end

  // --------------------------------------------------------------------------
  // Square root pipeline
  // --------------------------------------------------------------------------
  logic                          sr_vld, sr_zero;
  logic [hre_pkg::RootW-1:0]     sr_root;
  logic [hre_pkg::SqRemW-1:0]    sr_rem;

  hre_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s_vld_q),
    .zero_i (s_zero_q),
    .sq_i   (sum_q),
    .vld_o  (sr_vld),
    .zero_o (sr_zero),
    .root_o (sr_root),
    .rem_o  (sr_rem)
  );

  // --------------------------------------------------------------------------
  // Output stage: round the root, saturate or flag a zero denominator, drive the result beat
  // --------------------------------------------------------------------------
  logic [hre_pkg::RootW:0]       dist_r;
  logic                          dist_sat;
  logic                          res_vld_q;
  logic [hre_pkg::DistW-1:0]     dist_q;
  logic [hre_pkg::StatusW-1:0]   stat_q;

  always_comb begin
    dist_r   = {1'b0, sr_root} +
               (hre_pkg::RootW + 1)'(sr_rem > {2'b00, sr_root});
    dist_sat = dist_r > (hre_pkg::RootW + 1)'(hre_pkg::DistMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= sr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (sr_zero) begin
      dist_q <= '0;
      stat_q <= hre_pkg::StatZeroDen;
    end else if (dist_sat) begin
      dist_q <= hre_pkg::DistMax;
      stat_q <= hre_pkg::StatSat;
    end else begin
      dist_q <= dist_r[hre_pkg::DistW-1:0];
      stat_q <= hre_pkg::StatOk;
    end
  end

  assign result_valid_o = res_vld_q;
  assign distance_o     = dist_q;
  assign status_o       = stat_q;

endmodule

FILE: tb/sv/homography_reprojection_error_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_reprojection_error_unit_tb
// Drives point pairs through the unit under a series of matrix settings
// (reset identity, extremes, a singular row, random ones) and checks every
// distance and status beat against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module homography_reprojection_error_unit_tb;
  import hre_pkg::*;

  localparam int RunLatency = 80;

  // Expected reprojection results, in order, plus the matrix they depend on
  class reproj_scoreboard;
    longint m_xx, m_xy, m_ox, m_yx, m_yy, m_oy, m_px, m_py;
    logic [DistW-1:0]   exp_dist[$];
    logic [StatusW-1:0] exp_stat[$];
    int n_pairs, n_results, n_zero, n_sat, n_bad;

    function new();
      m_xx = 64'sd16777216; m_xy = 0; m_ox = 0;
      m_yx = 0; m_yy = 64'sd16777216; m_oy = 0;
      m_px = 0; m_py = 0;
    endfunction

    // Mirror one register write; unknown indexes change nothing
    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      longint v32, v40;
      v32 = longint'($signed(val[31:0]));
      v40 = longint'($signed(val[39:0]));
      case (idx)
        RegCoefXx:  m_xx = v32;
        RegCoefXy:  m_xy = v32;
        RegOffsetX: m_ox = v32;
        RegCoefYx:  m_yx = v32;
        RegCoefYy:  m_yy = v32;
        RegOffsetY: m_oy = v32;
        RegPerspX:  m_px = v40;
        RegPerspY:  m_py = v40;
        default: ;
      endcase
    endfunction

    // Quotient num * 2^22 / den, rounded half away from zero, clamped to 2^30
    function longint project(longint num, longint den);
      bit neg, big, b;
      longint unsigned n, d, rem, q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      rem = 0; q = 0; big = 0;
      for (int i = 71; i >= 0; i--) begin
        b = (i >= 22) ? ((n >> (i - 22)) & 1) : 1'b0;
        rem = (rem << 1) | b;
        b = 0;
        if (rem >= d) begin
          rem -= d;
          b = 1;
        end
        if ((q >> 40) != 0) big = 1;
        else q = (q << 1) | b;
      end
      if (!big && rem >= d - rem) q += 1;
      if (big || q > (64'd1 << 30)) q = 64'd1 << 30;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // Square root rounded to nearest
    function longint unsigned root_round(longint unsigned s);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > s) bt >>= 2;
      while (bt != 0) begin
        if (s >= res + bt) begin
          s -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      if (s > res) res += 1;
      return res;
    endfunction

    // Note an accepted pair and queue its expected result
    function void note_pair(logic [15:0] sx, logic [15:0] sy, logic [15:0] rx,
                            logic [15:0] ry);
      longint x, y, nu, nv, den, dx, dy;
      longint unsigned adx, ady, err_len;
      x = longint'($signed(sx));
      y = longint'($signed(sy));
      nu = m_xx * x + m_xy * y + m_ox * 4096;
      nv = m_yx * x + m_yy * y + m_oy * 4096;
      den = m_px * x + m_py * y + (64'sd1 <<< 42);
      n_pairs++;
      if (den == 0) begin
        exp_dist.push_back('0);
        exp_stat.push_back(StatZeroDen);
        n_zero++;
        return;
      end
      dx = project(nu, den) - longint'($signed(rx)) * 16;
      dy = project(nv, den) - longint'($signed(ry)) * 16;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      err_len = root_round(adx * adx + ady * ady);
      if (err_len > DistMax) begin
        exp_dist.push_back(DistMax);
        exp_stat.push_back(StatSat);
        n_sat++;
      end else begin
        exp_dist.push_back(err_len[DistW-1:0]);
        exp_stat.push_back(StatOk);
      end
    endfunction

    function void fail_note(string msg);
      n_bad++;
      if (n_bad <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [DistW-1:0] got_dist, logic [StatusW-1:0] stat);
      logic [DistW-1:0]   e_d;
      logic [StatusW-1:0] e_s;
      n_results++;
      if (exp_dist.size() == 0) begin
        fail_note($sformatf("unexpected result distance=%0d status=%0d", got_dist, stat));
        return;
      end
      e_d = exp_dist.pop_front();
      e_s = exp_stat.pop_front();
      if (got_dist !== e_d)
        fail_note($sformatf("result %0d distance exp %0d got %0d", n_results, e_d,
                            got_dist));
      if (stat !== e_s)
        fail_note($sformatf("result %0d status exp %0d got %0d", n_results, e_s, stat));
    endfunction

    function int pending();
      return exp_dist.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CoordW-1:0]    src_x_i = '0, src_y_i = '0, ref_x_i = '0, ref_y_i = '0;
  logic                 result_valid_o;
  logic [DistW-1:0]     distance_o;
  logic [StatusW-1:0]   status_o;

  reproj_scoreboard sb = new();

  homography_reprojection_error_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .start, .busy, .src_x_i, .src_y_i, .ref_x_i, .ref_y_i,
    .result_valid_o, .distance_o, .status_o
  );

  always #6 clk_i = ~clk_i;

  // Sample writes, accepted pairs and result beats at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_addr_i, cfg_wdata_i);
      if (start && !busy) sb.note_pair(src_x_i, src_y_i, ref_x_i, ref_y_i);
      if (result_valid_o) sb.check_result(distance_o, status_o);
    end
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("homography_reprojection_error_unit verification failed");
    $finish;
  end

  task automatic cfg_write(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold the pair until the unit takes it
  task automatic send_pair(logic [15:0] sx, logic [15:0] sy, logic [15:0] rx,
                           logic [15:0] ry);
    @(negedge clk_i);
    start <= 1'b1;
    src_x_i <= sx; src_y_i <= sy; ref_x_i <= rx; ref_y_i <= ry;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Wait for every expected beat, then let the pipe empty
  task automatic drain();
    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (RunLatency) @(posedge clk_i);
  endtask

  // Load all eight registers; 32-bit ones get junk in the unused top byte
  task automatic load_matrix(longint xx, longint xy, longint ox, longint yx,
                             longint yy, longint oy, longint px, longint py);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_write(RegCoefXx,  {junk, xx[31:0]});
    cfg_write(RegCoefXy,  {junk, xy[31:0]});
    cfg_write(RegOffsetX, {junk, ox[31:0]});
    cfg_write(RegCoefYx,  {junk, yx[31:0]});
    cfg_write(RegCoefYy,  {junk, yy[31:0]});
    cfg_write(RegOffsetY, {junk, oy[31:0]});
    cfg_write(RegPerspX,  px[39:0]);
    cfg_write(RegPerspY,  py[39:0]);
    // Stray writes past the register list must be dropped
    cfg_write(CfgAddrW'(RegPerspY + 1 + ($urandom % 8)),
              CfgDataW'({$urandom, $urandom}));
  endtask

  function automatic longint small_rand(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Near-identity matrix with mild perspective, or anything at all
  task automatic random_matrix();
    if ($urandom_range(0, 3) != 0)
      load_matrix(64'sd16777216 + small_rand(1 << 20), small_rand(1 << 20),
                  small_rand(1 << 22), small_rand(1 << 20),
                  64'sd16777216 + small_rand(1 << 20), small_rand(1 << 22),
                  small_rand(1 << 22), small_rand(1 << 22));
    else
      load_matrix(longint'($signed($urandom)), longint'($signed($urandom)),
                  longint'($signed($urandom)), longint'($signed($urandom)),
                  longint'($signed($urandom)), longint'($signed($urandom)),
                  longint'($signed({$urandom, $urandom} & 64'hff_ffff_ffff) <<< 24) >>> 24,
                  longint'($signed({$urandom, $urandom} & 64'hff_ffff_ffff) <<< 24) >>> 24);
  endtask

  // Bursts of pairs: mostly destinations close to the source, some noise,
  // and now and then x = 1.0 px to hit a singular row when one is loaded
  task automatic random_pairs(int count);
    logic [15:0] sx, sy, rx, ry;
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      sx = 16'($urandom); sy = 16'($urandom);
      if ($urandom_range(0, 9) == 0) sx = 16'sd16;
      if ($urandom_range(0, 4) != 0) begin
        rx = sx + 16'(small_rand(64));
        ry = sy + 16'(small_rand(64));
      end else begin
        rx = 16'($urandom); ry = 16'($urandom);
      end
      send_pair(sx, sy, rx, ry);
      if (burst == 0) begin
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 40);
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset identity: field extremes and an exact hit
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_pair(16'h1234, 16'hedcb, 16'h1234, 16'hedcc);
    random_pairs(60);
    drain();

    // All registers at their maximum, then at their minimum
    load_matrix(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
                64'sh7fffffff, 64'sh7fffffff, 64'sh7f_ffff_ffff, 64'sh7f_ffff_ffff);
    send_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_pair(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    random_pairs(60);
    drain();
    load_matrix(-64'sh80000000, -64'sh80000000, -64'sh80000000, -64'sh80000000,
                -64'sh80000000, -64'sh80000000, -64'sh80_0000_0000, -64'sh80_0000_0000);
    send_pair(16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h0001, 16'h7fff, 16'h8000);
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_pairs(60);
    drain();

    // Perspective row of -1.0 in x: the denominator vanishes at x = 1.0 px
    load_matrix(64'sd16777216, 0, 64'sd65536, 0, 64'sd16777216, -64'sd65536,
                -(64'sd1 <<< 38), 0);
    send_pair(16'sd16, 16'h7fff, 16'h0000, 16'h0000);
    send_pair(16'sd16, 16'h8000, 16'h7fff, 16'h8000);
    send_pair(16'sd15, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'sd17, 16'h0000, 16'h0000, 16'h0000);
    random_pairs(60);
    drain();

    // Random matrices
    for (int p = 0; p < 10; p++) begin
      random_matrix();
      random_pairs(75);
      drain();
    end

    $display("Covered %0d point pairs, %0d result beats (%0d singular, %0d saturated)",
             sb.n_pairs, sb.n_results, sb.n_zero, sb.n_sat);
    $display("over 14 matrix settings; %0d mismatches, %0d results still owed",
             sb.n_bad, sb.pending());
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("homography_reprojection_error_unit verification clean");
    end else begin
      $display("homography_reprojection_error_unit verification failed");
    end
    $finish;
  end

endmodule
